// ===== rtl/ssdg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step/direction generator package
// Command codes, field widths and register limits shared by the RTL and the
// port checker.
// ----------------------------------------------------------------------------
package ssdg_pkg;

	localparam int unsigned CMD_W     = 3;
	localparam int unsigned STEPS_IN_W = 32;
	localparam int unsigned STEPS_W   = 31;
	localparam int unsigned HP_W      = 19;

	localparam logic [HP_W-1:0]    HP_RESET    = 19'd1000;
	localparam logic [HP_W-1:0]    HP_MIN      = 19'd50;
	localparam logic [HP_W-1:0]    HP_MAX      = 19'd500000;
	localparam logic [HP_W-1:0]    ELAPSED_MAX = '1;
	localparam logic [STEPS_W-1:0] STEPS_MAX   = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_START_MOVE = 3'd1,
		CMD_START_CONT = 3'd2,
		CMD_STOP       = 3'd3,
		CMD_SET_ENABLE = 3'd4,
		CMD_SET_DIR    = 3'd5
	} cmd_t;

endpackage

// ===== rtl/stepper_step_dir_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step/direction generator
// Produces the step, direction and enable lines of a stepper driver from a
// stream of microsecond ticks and motion commands.
// ----------------------------------------------------------------------------
// The input channel carries one item per transfer: a microsecond tick or a
// command (start counted move, start continuous, stop, set enable, set
// direction). Every item gives exactly one result on the output channel,
// showing the driver lines and the motion state after that item.
// The item is captured in an input register; when it leaves that register
// the state update and the output register load happen together. The item
// waits there while the output register is full and stalled; otherwise one
// item is taken in every cycle.
// A new item is accepted while an earlier result waits to be taken: in_stall
// rises only when the input register is full and the output register is
// both full and stalled, so the receiver's stall reaches the sender in the
// same cycle once the input register holds an item.
// The half period register is written through cfg_we and cfg_wdata and is
// clamped into its legal range on the write.
// Reset clears both registers' valid flags and returns the driver to its
// idle state: step low, direction forward, driver disabled, no motion.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ssdg_pkg::HP_W-1:0]            cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ssdg_pkg::CMD_W-1:0]           cmd,
	input  logic signed [ssdg_pkg::STEPS_IN_W-1:0] move_steps,
	input  logic                                 level_flag,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 step_out,
	output logic                                 dir_out,
	output logic                                 enable_n_out,
	output logic                                 moving,
	output logic [ssdg_pkg::STEPS_W-1:0]         steps_left
);

	logic                               valid_s1;
	logic [ssdg_pkg::CMD_W-1:0]         cmd_s1;
	logic [ssdg_pkg::STEPS_IN_W-1:0]    move_steps_s1;
	logic                               level_flag_s1;

	logic [ssdg_pkg::HP_W-1:0]          half_period_q;
	logic                               step_level_q;
	logic                               dir_forward_q;
	logic                               drive_enabled_q;
	logic                               continuous_q;
	logic [ssdg_pkg::STEPS_W-1:0]       remaining_q;
	logic [ssdg_pkg::HP_W-1:0]          elapsed_q;

	logic                               step_level_d;
	logic                               dir_forward_d;
	logic                               drive_enabled_d;
	logic                               continuous_d;
	logic [ssdg_pkg::STEPS_W-1:0]       remaining_d;
	logic [ssdg_pkg::HP_W-1:0]          elapsed_d;

	logic                               out_valid_q;
	logic                               step_out_q;
	logic                               dir_out_q;
	logic                               enable_n_out_q;
	logic                               moving_q;
	logic [ssdg_pkg::STEPS_W-1:0]       steps_left_q;

	logic                               advance;
	logic                               process;
	logic [ssdg_pkg::HP_W-1:0]          hp_clamped;

	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		if (cfg_wdata < ssdg_pkg::HP_MIN) begin
			hp_clamped = ssdg_pkg::HP_MIN;
		end else if (cfg_wdata > ssdg_pkg::HP_MAX) begin
			hp_clamped = ssdg_pkg::HP_MAX;
		end else begin
			hp_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= ssdg_pkg::HP_RESET;
		end else if (cfg_we) begin
			half_period_q <= hp_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1        <= cmd;
			move_steps_s1 <= $unsigned(move_steps);
			level_flag_s1 <= level_flag;
		end
	end

	always_comb begin
		logic [ssdg_pkg::HP_W-1:0]       elapsed_inc;
		logic [ssdg_pkg::STEPS_IN_W-1:0] magnitude;
		logic                            want;
		logic                            toggled;

		step_level_d    = step_level_q;
		dir_forward_d   = dir_forward_q;
		drive_enabled_d = drive_enabled_q;
		continuous_d    = continuous_q;
		remaining_d     = remaining_q;
		elapsed_d       = elapsed_q;

		elapsed_inc = (elapsed_q == ssdg_pkg::ELAPSED_MAX) ? elapsed_q
			: elapsed_q + 19'd1;
		want      = drive_enabled_q && (continuous_q || (remaining_q != '0));
		toggled   = !step_level_q;
		magnitude = ~move_steps_s1 + 32'd1;

		unique case (ssdg_pkg::cmd_t'(cmd_s1))
			ssdg_pkg::CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (want) begin
					if (elapsed_inc >= half_period_q) begin
						step_level_d = toggled;
						elapsed_d    = '0;
						if (!toggled && (remaining_q != '0)) begin
							remaining_d = remaining_q - 31'd1;
						end
					end
				end else begin
					step_level_d = 1'b0;
				end
			end
			ssdg_pkg::CMD_START_MOVE: begin
				drive_enabled_d = 1'b1;
				continuous_d    = 1'b0;
				if (move_steps_s1[ssdg_pkg::STEPS_IN_W-1]) begin
					dir_forward_d = 1'b0;
					if (magnitude[ssdg_pkg::STEPS_IN_W-1]) begin
						remaining_d = ssdg_pkg::STEPS_MAX;
					end else begin
						remaining_d = magnitude[ssdg_pkg::STEPS_W-1:0];
					end
				end else begin
					remaining_d = move_steps_s1[ssdg_pkg::STEPS_W-1:0];
				end
			end
			ssdg_pkg::CMD_START_CONT: begin
				continuous_d = 1'b1;
				remaining_d  = '0;
			end
			ssdg_pkg::CMD_STOP: begin
				continuous_d = 1'b0;
				remaining_d  = '0;
				step_level_d = 1'b0;
			end
			ssdg_pkg::CMD_SET_ENABLE: begin
				drive_enabled_d = level_flag_s1;
			end
			ssdg_pkg::CMD_SET_DIR: begin
				dir_forward_d = level_flag_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_level_q    <= 1'b0;
			dir_forward_q   <= 1'b1;
			drive_enabled_q <= 1'b0;
			continuous_q    <= 1'b0;
			remaining_q     <= '0;
			elapsed_q       <= '0;
		end else if (process) begin
			step_level_q    <= step_level_d;
			dir_forward_q   <= dir_forward_d;
			drive_enabled_q <= drive_enabled_d;
			continuous_q    <= continuous_d;
			remaining_q     <= remaining_d;
			elapsed_q       <= elapsed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			step_out_q     <= step_level_d;
			dir_out_q      <= dir_forward_d;
			enable_n_out_q <= !drive_enabled_d;
			moving_q       <= continuous_d || (remaining_d != '0);
			steps_left_q   <= remaining_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign step_out     = step_out_q;
	assign dir_out      = dir_out_q;
	assign enable_n_out = enable_n_out_q;
	assign moving       = moving_q;
	assign steps_left   = steps_left_q;

endmodule

// ===== rtl/ssdg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step/direction generator port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module ssdg_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic                                   step_out,
	input logic                                   dir_out,
	input logic                                   enable_n_out,
	input logic                                   moving,
	input logic [ssdg_pkg::STEPS_W-1:0]           steps_left
);

	a_out_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result withdrawn while stalled.");

	a_out_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(step_out) && $stable(dir_out)
			&& $stable(enable_n_out) && $stable(moving) && $stable(steps_left))
		else $error("Result changed while stalled.");

	a_steps_imply_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (steps_left != '0) |-> moving)
		else $error("Steps remain but motion is not reported.");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("Input stalled while the output register is empty.");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("Channels active during reset.");

endmodule

bind stepper_step_dir_generator ssdg_checker u_ssdg_checker (.*);
